/* hw/rtl/skf_pkg.sv */
`timescale 1ns / 1ps
// Package for the scalar Kalman filter core: fixed-point widths, payload
// structs, microcode word format and the control program. No dependencies.
package skf_pkg;

    localparam int MEAS_W     = 12;
    localparam int EST_FRAC   = 16;
    localparam int EST_W      = MEAS_W + EST_FRAC;
    localparam int COV_FRAC   = 30;
    localparam int GAIN_W     = COV_FRAC + 1;
    localparam int COV_W      = 32;
    localparam int NOISE_W    = 31;
    localparam int DEN_W      = COV_W + 1;
    localparam int REM_W      = COV_W + 2;
    localparam int MUL_A_W    = COV_W;
    localparam int MUL_B_W    = GAIN_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 3;

    localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(GAIN_W - 1);
    localparam logic [GAIN_W-1:0]  UNITY     = GAIN_W'(1) << COV_FRAC;
    localparam logic [PROD_W-1:0]  ROUND_ADD = (PROD_W'(1) << COV_FRAC) - PROD_W'(1);

    localparam logic [NOISE_W-1:0] PN_RESET  = NOISE_W'(107374);
    localparam logic [NOISE_W-1:0] MN_RESET  = NOISE_W'(10737418);
    localparam logic [NOISE_W-1:0] IC_RESET  = NOISE_W'(1073741824);
    localparam logic [EST_W-1:0]   IE_RESET  = EST_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE     = 4'd0,
        REG_MEASUREMENT_NOISE = 4'd1,
        REG_INITIAL_COV       = 4'd2,
        REG_INITIAL_EST       = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [MEAS_W-1:0] measurement;
        logic              restart;
    } in_item_t;

    typedef struct packed {
        logic [EST_W-1:0]  estimate;
        logic [GAIN_W-1:0] gain;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_PREDICT,
        OP_DENOM,
        OP_DIVIDE,
        OP_MUL_GAIN,
        OP_UPDATE_EST,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        C_NEVER,
        C_NO_INPUT,
        C_CNT_NZ,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic [STEP_W-1:0] next;
    } uword_t;

    typedef struct packed {
        logic no_input;
        logic cnt_nz;
        logic out_busy;
    } status_t;

    localparam logic [STEP_W-1:0] ST_ACCEPT  = 3'd0;
    localparam logic [STEP_W-1:0] ST_PREDICT = 3'd1;
    localparam logic [STEP_W-1:0] ST_DENOM   = 3'd2;
    localparam logic [STEP_W-1:0] ST_DIVIDE  = 3'd3;
    localparam logic [STEP_W-1:0] ST_MUL     = 3'd4;
    localparam logic [STEP_W-1:0] ST_UPDATE  = 3'd5;
    localparam logic [STEP_W-1:0] ST_EMIT    = 3'd6;

    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            ST_ACCEPT:  w = '{OP_ACCEPT,     C_NO_INPUT, ST_ACCEPT, ST_PREDICT};
            ST_PREDICT: w = '{OP_PREDICT,    C_NEVER,    ST_ACCEPT, ST_DENOM};
            ST_DENOM:   w = '{OP_DENOM,      C_NEVER,    ST_ACCEPT, ST_DIVIDE};
            ST_DIVIDE:  w = '{OP_DIVIDE,     C_CNT_NZ,   ST_DIVIDE, ST_MUL};
            ST_MUL:     w = '{OP_MUL_GAIN,   C_NEVER,    ST_ACCEPT, ST_UPDATE};
            ST_UPDATE:  w = '{OP_UPDATE_EST, C_NEVER,    ST_ACCEPT, ST_EMIT};
            ST_EMIT:    w = '{OP_EMIT,       C_OUT_BUSY, ST_EMIT,   ST_ACCEPT};
            default:    w = '{OP_ACCEPT,     C_NEVER,    ST_ACCEPT, ST_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/skf_sequencer.sv */
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control word lookup and branch logic.
// Depends on skf_pkg.
module skf_sequencer import skf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output uword_t  uword
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              taken;

    assign uword = ucode_rom(step_reg);

    always_comb begin
        case (uword.cond)
            C_NEVER:    taken = 1'b0;
            C_NO_INPUT: taken = status.no_input;
            C_CNT_NZ:   taken = status.cnt_nz;
            C_OUT_BUSY: taken = status.out_busy;
            default:    taken = 1'b0;
        endcase
        step_next = taken ? uword.target : uword.next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_ACCEPT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

/* hw/rtl/skf_datapath.sv */
`timescale 1ns / 1ps
// Filter datapath: config registers, state, restoring divider, shared
// multiplier and result register. Driven by the control word; needs skf_pkg.
module skf_datapath import skf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  uword_t                uword,
    output status_t               status,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [NOISE_W-1:0] pn_reg, mn_reg, ic_reg;
    logic [EST_W-1:0]   ie_reg;
    logic [EST_W-1:0]   est_reg, est_next;
    logic [COV_W-1:0]   cov_reg, cov_next;
    logic [MEAS_W-1:0]  meas_reg;
    logic [COV_W-1:0]   ppred_reg;
    logic [DEN_W-1:0]   denom_reg;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [GAIN_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [EST_W-1:0]   diff_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               accept, emit, out_busy;
    logic [DEN_W-1:0]   pred_sum;
    logic [COV_W-1:0]   ppred_sat;
    logic [EST_W-1:0]   z_fx;
    logic               z_below;
    logic               div_ge;
    logic [REM_W-1:0]   rem_sub;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_next;
    logic [PROD_W-1:0]  prod_round;
    logic [EST_W-1:0]   step_dn, step_up;

    assign cfg_ready = 1'b1;
    assign out_busy  = out_valid_reg && !m_ready;
    assign s_ready   = (uword.op == OP_ACCEPT);
    assign accept    = s_ready && s_valid;
    assign emit      = (uword.op == OP_EMIT) && !out_busy;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    assign status.no_input = !s_valid;
    assign status.cnt_nz   = (cnt_reg != '0);
    assign status.out_busy = out_busy;

    always_comb begin
        pred_sum  = {1'b0, cov_reg} + {2'b0, pn_reg};
        ppred_sat = pred_sum[COV_W] ? '1 : pred_sum[COV_W-1:0];
        z_fx      = {meas_reg, EST_FRAC'(0)};
        z_below   = (z_fx < est_reg);

        div_ge    = (denom_reg != '0) && (rem_reg >= {1'b0, denom_reg});
        rem_sub   = div_ge ? (rem_reg - {1'b0, denom_reg}) : rem_reg;
        rem_next  = {rem_sub[REM_W-2:0], 1'b0};
        quo_next  = {quo_reg[GAIN_W-2:0], div_ge};

        if (uword.op == OP_MUL_GAIN) begin
            mul_a = {(MUL_A_W - EST_W)'(0), diff_reg};
            mul_b = quo_reg;
        end else begin
            mul_a = ppred_reg;
            mul_b = UNITY - quo_reg;
        end
        prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);

        prod_round = prod_reg + ROUND_ADD;
        step_up    = prod_reg[COV_FRAC +: EST_W];
        step_dn    = prod_round[COV_FRAC +: EST_W];
        est_next   = neg_reg ? (est_reg - step_dn) : (est_reg + step_up);
        cov_next   = prod_reg[COV_FRAC +: COV_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_reg        <= PN_RESET;
            mn_reg        <= MN_RESET;
            ic_reg        <= IC_RESET;
            ie_reg        <= IE_RESET;
            est_reg       <= IE_RESET;
            cov_reg       <= {1'b0, IC_RESET};
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PROCESS_NOISE:     pn_reg <= cfg_data[NOISE_W-1:0];
                    REG_MEASUREMENT_NOISE: mn_reg <= cfg_data[NOISE_W-1:0];
                    REG_INITIAL_COV:       ic_reg <= cfg_data[NOISE_W-1:0];
                    REG_INITIAL_EST:       ie_reg <= cfg_data[EST_W-1:0];
                    default: ;
                endcase
            end
            if (accept && s_data.restart) begin
                est_reg <= ie_reg;
                cov_reg <= {1'b0, ic_reg};
            end
            if (uword.op == OP_UPDATE_EST) begin
                est_reg <= est_next;
            end
            if (emit) begin
                cov_reg       <= cov_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            meas_reg <= s_data.measurement;
        end
        case (uword.op)
            OP_PREDICT: begin
                ppred_reg <= ppred_sat;
                neg_reg   <= z_below;
                diff_reg  <= z_below ? (est_reg - z_fx) : (z_fx - est_reg);
            end
            OP_DENOM: begin
                denom_reg <= {1'b0, ppred_reg} + {2'b0, mn_reg};
                rem_reg   <= {2'b0, ppred_reg};
                quo_reg   <= '0;
                cnt_reg   <= DIV_LAST;
            end
            OP_DIVIDE: begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            OP_MUL_GAIN, OP_UPDATE_EST: begin
                prod_reg <= prod_next;
            end
            default: ;
        endcase
        if (emit) begin
            out_data_reg.estimate <= est_reg;
            out_data_reg.gain     <= quo_reg;
        end
    end

endmodule

/* hw/rtl/scalar_kalman_filter_core.sv */
`timescale 1ns / 1ps
// Scalar Kalman filter core, top level: sequencer plus datapath.
// Depends on skf_pkg, skf_sequencer and skf_datapath.
//
// One ADC code in, one filtered estimate (Q12.16) and the gain used (Q1.30)
// out per transfer. Items are processed one at a time: each occupies the core
// for the 31 one-bit steps of the restoring gain divider plus six steps of
// the microprogram (accept, predict, divisor, two passes through the shared
// multiplier, emit). The result register loads in the emit step, and the next
// input transfer can follow in the cycle after. A pending result that is not
// taken holds the core in its emit step; otherwise the result register frees
// the core to accept the next item at once. Configuration writes are accepted
// every cycle and must only be issued while the core is idle.
module scalar_kalman_filter_core import skf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    uword_t  uword;
    status_t status;

    skf_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .uword   (uword)
    );

    skf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .uword     (uword),
        .status    (status),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input transfer while an item is in flight");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.gain <= UNITY))
        else $error("gain above unity");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result issued right after input transfer");

endmodule
